// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Static linked list engine package
// Shared transaction types, opcode and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  // Opcodes of a command transaction.
  localparam logic [3:0] OP_PUSH_BACK    = 4'd0;
  localparam logic [3:0] OP_PUSH_FRONT   = 4'd1;
  localparam logic [3:0] OP_POP_BACK     = 4'd2;
  localparam logic [3:0] OP_POP_FRONT    = 4'd3;
  localparam logic [3:0] OP_INSERT       = 4'd4;
  localparam logic [3:0] OP_GET          = 4'd5;
  localparam logic [3:0] OP_LENGTH       = 4'd6;
  localparam logic [3:0] OP_DELETE_VALUE = 4'd7;
  localparam logic [3:0] OP_DELETE_AT    = 4'd8;
  localparam logic [3:0] OP_REVERSE      = 4'd9;
  localparam logic [3:0] OP_SORT         = 4'd10;
  localparam logic [3:0] OP_CLEAR        = 4'd11;
  localparam logic [3:0] OP_FIND         = 4'd12;

  // Result status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_RANGE    = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] value_in;
    logic [4:0]         position;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [4:0]         count_or_position;
    logic [2:0]         status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_WALK_EV,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_INS_D,
    S_UNL_A,
    S_UNL_B,
    S_UNL_C,
    S_UNL_D,
    S_GET_RD,
    S_GET_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_REV_RD,
    S_REV_EV,
    S_CLR_RD,
    S_CLR_EV,
    S_SRT_A,
    S_SRT_B,
    S_SRT_O,
    S_SRT_K,
    S_SRT_I,
    S_SRT_S,
    S_SRT_V,
    S_SRT_W1,
    S_SRT_W2
  } sle_state_e;

endpackage

`default_nettype wire

// ===== design/sle_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order, read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/static_linked_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// Static linked list engine
// Cursor-linked list of signed values with a free list, held in two RAMs.
// ----------------------------------------------------------------------------
// Length and rejected commands give done_o in the cycle after acceptance;
//   others take time that grows with the nodes visited by the list walk, and
//   sort with its inner comparisons for each element.
// Throughput: one transaction at a time; the link RAM read port sets the pace.
// Reset: a sweep over nodes 2 to NODE_COUNT-1 builds the free chain; busy is high.
// The receiver cannot stall; done_o marks each result for one cycle.
`default_nettype none

module static_linked_list_engine_core #(
  parameter int NODE_COUNT = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire sle_pkg::cmd_t cmd_i,
  output logic               done_o,
  output sle_pkg::rsp_t      rsp_o
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = ((IW > 5) ? IW : 5) + 1;
  localparam logic [IW-1:0] LastNode = IW'(NODE_COUNT - 1);

  sle_pkg::sle_state_e state_q, state_d;
  sle_pkg::cmd_t       cmd_q, cmd_d;
  sle_pkg::rsp_t       rsp_q, rsp_d;
  logic                done_q, done_d;

  logic [IW-1:0] hd_q, hd_d;      // link of node 0
  logic [IW-1:0] fh_q, fh_d;      // link of node 1
  logic [IW-1:0] len_q, len_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] succ_q, succ_d;
  logic [IW-1:0] nx_q, nx_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] lim_q, lim_d;
  logic [IW-1:0] steps_q, steps_d;
  logic [IW-1:0] ra_q;
  logic [31:0]   key_q, key_d;

  logic          n_we, v_we;
  logic [IW-1:0] n_wa, n_wd, n_ra, n_rd, v_wa, v_ra;
  logic [31:0]   v_wd, v_rd;

  logic          lw_en;
  logic [IW-1:0] lw_addr, lw_data;

  logic          accept;
  logic [IW-1:0] lnk;
  logic [CW-1:0] pos_x, len_x, cnt1_x;
  logic [IW-1:0] cnt1;

  assign accept = start && !busy;
  assign busy   = (state_q != sle_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Link of the node read last cycle; nodes 0 and 1 live in registers.
  assign lnk = (ra_q == IW'(0)) ? hd_q : ((ra_q == IW'(1)) ? fh_q : n_rd);

  assign pos_x  = CW'(cmd_i.position);
  assign len_x  = CW'(len_q);
  assign cnt1   = cnt_q + IW'(1);
  assign cnt1_x = CW'(cnt1);

  sle_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_wa),
    .wdata_i(n_wd),
    .raddr_i(n_ra),
    .rdata_o(n_rd)
  );

  sle_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_wa),
    .wdata_i(v_wd),
    .raddr_i(v_ra),
    .rdata_o(v_rd)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sle_pkg::S_INIT: begin
        if (cur_q == LastNode) state_d = sle_pkg::S_IDLE;
      end
      sle_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd_i.opcode)
            sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT: begin
              if (fh_q != '0) state_d = sle_pkg::S_WALK;
            end
            sle_pkg::OP_INSERT: begin
              if (fh_q != '0 && pos_x != '0 && pos_x <= len_x + CW'(1)) begin
                state_d = sle_pkg::S_WALK;
              end
            end
            sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT: begin
              if (len_q != '0) state_d = sle_pkg::S_WALK;
            end
            sle_pkg::OP_GET, sle_pkg::OP_DELETE_AT: begin
              if (pos_x != '0 && pos_x <= len_x) state_d = sle_pkg::S_WALK;
            end
            sle_pkg::OP_DELETE_VALUE, sle_pkg::OP_FIND: begin
              if (len_q != '0) state_d = sle_pkg::S_SCAN_RD;
            end
            sle_pkg::OP_REVERSE: begin
              if (len_q > IW'(1)) state_d = sle_pkg::S_REV_RD;
            end
            sle_pkg::OP_SORT: begin
              if (len_q > IW'(1)) state_d = sle_pkg::S_SRT_A;
            end
            sle_pkg::OP_CLEAR: begin
              if (len_q != '0) state_d = sle_pkg::S_CLR_RD;
            end
            default: state_d = sle_pkg::S_IDLE;
          endcase
        end
      end
      sle_pkg::S_WALK: begin
        if (cnt_q == steps_q) begin
          case (cmd_q.opcode)
            sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT,
            sle_pkg::OP_INSERT: state_d = sle_pkg::S_INS_A;
            sle_pkg::OP_GET:    state_d = sle_pkg::S_GET_RD;
            default:            state_d = sle_pkg::S_UNL_A;
          endcase
        end else begin
          state_d = sle_pkg::S_WALK_EV;
        end
      end
      sle_pkg::S_WALK_EV: state_d = sle_pkg::S_WALK;
      sle_pkg::S_INS_A:   state_d = sle_pkg::S_INS_B;
      sle_pkg::S_INS_B:   state_d = sle_pkg::S_INS_C;
      sle_pkg::S_INS_C:   state_d = sle_pkg::S_INS_D;
      sle_pkg::S_INS_D:   state_d = sle_pkg::S_IDLE;
      sle_pkg::S_UNL_A:   state_d = sle_pkg::S_UNL_B;
      sle_pkg::S_UNL_B:   state_d = sle_pkg::S_UNL_C;
      sle_pkg::S_UNL_C:   state_d = sle_pkg::S_UNL_D;
      sle_pkg::S_UNL_D:   state_d = sle_pkg::S_IDLE;
      sle_pkg::S_GET_RD:  state_d = sle_pkg::S_GET_EV;
      sle_pkg::S_GET_EV:  state_d = sle_pkg::S_IDLE;
      sle_pkg::S_SCAN_RD: state_d = sle_pkg::S_SCAN_EV;
      sle_pkg::S_SCAN_EV: begin
        if (v_rd == cmd_q.value_in) begin
          state_d = (cmd_q.opcode == sle_pkg::OP_FIND) ? sle_pkg::S_IDLE
                                                       : sle_pkg::S_UNL_A;
        end else if (cnt1 == lim_q) begin
          state_d = sle_pkg::S_IDLE;
        end else begin
          state_d = sle_pkg::S_SCAN_RD;
        end
      end
      sle_pkg::S_REV_RD: state_d = sle_pkg::S_REV_EV;
      sle_pkg::S_REV_EV: begin
        state_d = (cnt1 == lim_q) ? sle_pkg::S_IDLE : sle_pkg::S_REV_RD;
      end
      sle_pkg::S_CLR_RD: state_d = sle_pkg::S_CLR_EV;
      sle_pkg::S_CLR_EV: begin
        state_d = (cnt1 == lim_q) ? sle_pkg::S_IDLE : sle_pkg::S_CLR_RD;
      end
      sle_pkg::S_SRT_A: state_d = sle_pkg::S_SRT_B;
      sle_pkg::S_SRT_B: state_d = sle_pkg::S_SRT_O;
      sle_pkg::S_SRT_O: begin
        state_d = (cnt_q == lim_q) ? sle_pkg::S_IDLE : sle_pkg::S_SRT_K;
      end
      sle_pkg::S_SRT_K: state_d = sle_pkg::S_SRT_I;
      sle_pkg::S_SRT_I: state_d = sle_pkg::S_SRT_S;
      sle_pkg::S_SRT_S: begin
        state_d = (lnk == '0) ? sle_pkg::S_SRT_W1 : sle_pkg::S_SRT_V;
      end
      sle_pkg::S_SRT_V: begin
        state_d = ($signed(v_rd) < $signed(key_q)) ? sle_pkg::S_SRT_I
                                                  : sle_pkg::S_SRT_W1;
      end
      sle_pkg::S_SRT_W1: state_d = sle_pkg::S_SRT_W2;
      sle_pkg::S_SRT_W2: state_d = sle_pkg::S_SRT_O;
      default:           state_d = sle_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory accesses and results for each state.
  always_comb begin
    cmd_d   = cmd_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    hd_d    = hd_q;
    fh_d    = fh_q;
    len_d   = len_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    k_d     = k_q;
    succ_d  = succ_q;
    nx_d    = nx_q;
    cnt_d   = cnt_q;
    lim_d   = lim_q;
    steps_d = steps_q;
    key_d   = key_q;
    n_ra    = cur_q;
    v_ra    = cur_q;
    v_we    = 1'b0;
    v_wa    = k_q;
    v_wd    = cmd_q.value_in;
    lw_en   = 1'b0;
    lw_addr = cur_q;
    lw_data = '0;
    unique case (state_q)
      sle_pkg::S_INIT: begin
        lw_en   = 1'b1;
        lw_addr = cur_q;
        lw_data = (cur_q == LastNode) ? '0 : cur_q + IW'(1);
        cur_d   = cur_q + IW'(1);
      end
      sle_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i;
          rsp_d   = '0;
          k_d     = fh_q;
          cur_d   = '0;
          prev_d  = '0;
          cnt_d   = '0;
          lim_d   = len_q;
          steps_d = '0;
          case (cmd_i.opcode)
            sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT: begin
              steps_d = (cmd_i.opcode == sle_pkg::OP_PUSH_BACK) ? len_q : '0;
              if (fh_q == '0) begin
                rsp_d.status = sle_pkg::STAT_FULL;
                done_d       = 1'b1;
              end
            end
            sle_pkg::OP_INSERT: begin
              steps_d = IW'(cmd_i.position - 5'd1);
              if (fh_q == '0) begin
                rsp_d.status = sle_pkg::STAT_FULL;
                done_d       = 1'b1;
              end else if (pos_x == '0 || pos_x > len_x + CW'(1)) begin
                rsp_d.status = sle_pkg::STAT_RANGE;
                done_d       = 1'b1;
              end
            end
            sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT: begin
              steps_d = (cmd_i.opcode == sle_pkg::OP_POP_BACK) ? len_q - IW'(1) : '0;
              if (len_q == '0) begin
                rsp_d.status = sle_pkg::STAT_EMPTY;
                done_d       = 1'b1;
              end
            end
            sle_pkg::OP_GET, sle_pkg::OP_DELETE_AT: begin
              steps_d = (cmd_i.opcode == sle_pkg::OP_GET) ? IW'(cmd_i.position)
                                                          : IW'(cmd_i.position - 5'd1);
              if (pos_x == '0 || pos_x > len_x) begin
                rsp_d.status = sle_pkg::STAT_RANGE;
                done_d       = 1'b1;
              end
            end
            sle_pkg::OP_LENGTH: begin
              rsp_d.count_or_position = 5'(len_x);
              done_d                  = 1'b1;
            end
            sle_pkg::OP_DELETE_VALUE, sle_pkg::OP_FIND: begin
              rsp_d.status = sle_pkg::STAT_NOTFOUND;
              cur_d        = hd_q;
              if (len_q == '0) done_d = 1'b1;
            end
            sle_pkg::OP_REVERSE: begin
              cur_d = hd_q;
              if (len_q > IW'(1)) hd_d = '0;
              else done_d = 1'b1;
            end
            sle_pkg::OP_SORT: begin
              if (len_q < IW'(2)) done_d = 1'b1;
            end
            sle_pkg::OP_CLEAR: begin
              cur_d = hd_q;
              hd_d  = '0;
              len_d = '0;
              if (len_q == '0) done_d = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      sle_pkg::S_WALK: begin
        prev_d = cur_q;
        n_ra   = cur_q;
      end
      sle_pkg::S_WALK_EV: begin
        cur_d = lnk;
        cnt_d = cnt1;
      end
      // Insert a node taken from the free list after prev.
      sle_pkg::S_INS_A: n_ra = prev_q;
      sle_pkg::S_INS_B: begin
        succ_d = lnk;
        n_ra   = k_q;
      end
      sle_pkg::S_INS_C: begin
        fh_d    = lnk;
        lw_en   = 1'b1;
        lw_addr = k_q;
        lw_data = succ_q;
        v_we    = 1'b1;
      end
      sle_pkg::S_INS_D: begin
        lw_en   = 1'b1;
        lw_addr = prev_q;
        lw_data = k_q;
        len_d   = len_q + IW'(1);
        done_d  = 1'b1;
      end
      // Unlink the successor of prev and return it to the free list.
      sle_pkg::S_UNL_A: n_ra = prev_q;
      sle_pkg::S_UNL_B: begin
        k_d  = lnk;
        n_ra = lnk;
        v_ra = lnk;
      end
      sle_pkg::S_UNL_C: begin
        rsp_d.value_out = v_rd;
        rsp_d.status    = sle_pkg::STAT_OK;
        lw_en           = 1'b1;
        lw_addr         = prev_q;
        lw_data         = lnk;
      end
      sle_pkg::S_UNL_D: begin
        lw_en   = 1'b1;
        lw_addr = k_q;
        lw_data = fh_q;
        fh_d    = k_q;
        len_d   = len_q - IW'(1);
        done_d  = 1'b1;
      end
      sle_pkg::S_GET_RD: v_ra = cur_q;
      sle_pkg::S_GET_EV: begin
        rsp_d.value_out = v_rd;
        done_d          = 1'b1;
      end
      // Linear search by value.
      sle_pkg::S_SCAN_RD: begin
        n_ra = cur_q;
        v_ra = cur_q;
      end
      sle_pkg::S_SCAN_EV: begin
        if (v_rd == cmd_q.value_in) begin
          rsp_d.status = sle_pkg::STAT_OK;
          if (cmd_q.opcode == sle_pkg::OP_FIND) begin
            rsp_d.count_or_position = cnt1_x[4:0];
            done_d                  = 1'b1;
          end
        end else begin
          if (cnt1 == lim_q) done_d = 1'b1;
          prev_d = cur_q;
          cur_d  = lnk;
          cnt_d  = cnt1;
        end
      end
      // Reverse: move each node to the front of a new list.
      sle_pkg::S_REV_RD: n_ra = cur_q;
      sle_pkg::S_REV_EV: begin
        lw_en   = 1'b1;
        lw_addr = cur_q;
        lw_data = hd_q;
        hd_d    = cur_q;
        cur_d   = lnk;
        cnt_d   = cnt1;
        if (cnt1 == lim_q) done_d = 1'b1;
      end
      // Clear: push each node onto the free list.
      sle_pkg::S_CLR_RD: n_ra = cur_q;
      sle_pkg::S_CLR_EV: begin
        lw_en   = 1'b1;
        lw_addr = cur_q;
        lw_data = fh_q;
        fh_d    = cur_q;
        cur_d   = lnk;
        cnt_d   = cnt1;
        if (cnt1 == lim_q) done_d = 1'b1;
      end
      // Insertion sort: detach the tail after the first node, then
      // insert each detached node before the first one not smaller.
      sle_pkg::S_SRT_A: n_ra = hd_q;
      sle_pkg::S_SRT_B: begin
        cur_d   = lnk;
        lw_en   = 1'b1;
        lw_addr = hd_q;
        lw_data = '0;
        cnt_d   = IW'(1);
      end
      sle_pkg::S_SRT_O: begin
        n_ra = cur_q;
        v_ra = cur_q;
        if (cnt_q == lim_q) done_d = 1'b1;
      end
      sle_pkg::S_SRT_K: begin
        nx_d   = lnk;
        key_d  = v_rd;
        prev_d = '0;
      end
      sle_pkg::S_SRT_I: n_ra = prev_q;
      sle_pkg::S_SRT_S: begin
        succ_d = lnk;
        v_ra   = lnk;
      end
      sle_pkg::S_SRT_V: begin
        if ($signed(v_rd) < $signed(key_q)) prev_d = succ_q;
      end
      sle_pkg::S_SRT_W1: begin
        lw_en   = 1'b1;
        lw_addr = cur_q;
        lw_data = succ_q;
      end
      sle_pkg::S_SRT_W2: begin
        lw_en   = 1'b1;
        lw_addr = prev_q;
        lw_data = cur_q;
        cur_d   = nx_q;
        cnt_d   = cnt1;
      end
      default: done_d = 1'b0;
    endcase

    // Link writes to nodes 0 and 1 go to the head registers.
    n_we = 1'b0;
    n_wa = lw_addr;
    n_wd = lw_data;
    if (lw_en) begin
      if (lw_addr == IW'(0)) hd_d = lw_data;
      else if (lw_addr == IW'(1)) fh_d = lw_data;
      else n_we = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sle_pkg::S_INIT;
      done_q  <= 1'b0;
      hd_q    <= '0;
      fh_q    <= IW'(2);
      len_q   <= '0;
      cur_q   <= IW'(2);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      hd_q    <= hd_d;
      fh_q    <= fh_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rsp_q   <= rsp_d;
    prev_q  <= prev_d;
    k_q     <= k_d;
    succ_q  <= succ_d;
    nx_q    <= nx_d;
    lim_q   <= lim_d;
    steps_q <= steps_d;
    key_q   <= key_d;
    ra_q    <= n_ra;
  end

endmodule

`default_nettype wire

// ===== design/sle_checker.sv =====
// ----------------------------------------------------------------------------
// Static linked list engine port checker
// Checks the command and result behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire sle_pkg::rsp_t rsp_o
);

  // A result only follows an accepted transaction or a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a transaction in flight");

  // An accepted transaction either finishes at once or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction vanished");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status <= sle_pkg::STAT_NOTFOUND))
    else $error("undefined status");

  // A full store reports no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == sle_pkg::STAT_FULL)
      |-> (rsp_o.value_out == '0 && rsp_o.count_or_position == '0))
    else $error("full status with data");

endmodule

bind static_linked_list_engine_core sle_checker u_sle_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

`default_nettype wire

// ===== tb/sv/static_linked_list_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// Static linked list engine testbench
// Drives command transactions into the engine, predicts each response with a
// behavioral list model, and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module static_linked_list_engine_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 16;

  // Scoreboard: a behavioral copy of the node store and a queue of expected
  // responses.
  class list_scoreboard;
    logic [4:0]     link_mem[NODES];
    logic [31:0]    data_mem[NODES];
    sle_pkg::rsp_t  pending_rsp[$];
    int             mismatches;
    int             checked;

    function new();
      mismatches = 0;
      checked = 0;
      for (int i = 0; i < NODES; i++) begin
        link_mem[i] = (i >= 1 && i + 1 < NODES) ? 5'(i + 1) : 5'd0;
        data_mem[i] = '0;
      end
    endfunction

    function int list_len();
      int n;
      logic [4:0] cur;
      n = 0;
      cur = link_mem[0];
      while (cur != 0 && n < NODES) begin
        cur = link_mem[cur];
        n++;
      end
      return n;
    endfunction

    function logic [4:0] node_after(int steps);
      logic [4:0] cur;
      cur = 0;
      for (int c = 0; c < steps && c < NODES; c++) cur = link_mem[cur];
      return cur;
    endfunction

    function void release_node(logic [4:0] k);
      link_mem[k] = link_mem[1];
      link_mem[1] = k;
    endfunction

    function logic [31:0] unlink_after(logic [4:0] prev);
      logic [4:0] t;
      t = link_mem[prev];
      link_mem[prev] = link_mem[t];
      release_node(t);
      return data_mem[t];
    endfunction

    function void link_in(logic [4:0] prev, logic [31:0] v);
      logic [4:0] k;
      k = link_mem[1];
      link_mem[1] = link_mem[k];
      data_mem[k] = v;
      link_mem[k] = link_mem[prev];
      link_mem[prev] = k;
    endfunction

    // Applies one accepted command to the model and queues its response.
    function void note_command(sle_pkg::cmd_t cmd);
      sle_pkg::rsp_t r;
      int len, pos;
      logic [4:0] cur, nx, prev, s;
      r = '0;
      len = list_len();
      pos = cmd.position;
      case (cmd.opcode)
        sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT: begin
          if (link_mem[1] == 0) r.status = sle_pkg::STAT_FULL;
          else link_in(cmd.opcode == sle_pkg::OP_PUSH_BACK ? node_after(len) : 5'd0,
                       cmd.value_in);
        end
        sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT: begin
          if (len == 0) r.status = sle_pkg::STAT_EMPTY;
          else r.value_out = unlink_after(cmd.opcode == sle_pkg::OP_POP_BACK ?
                                          node_after(len - 1) : 5'd0);
        end
        sle_pkg::OP_INSERT: begin
          if (link_mem[1] == 0) r.status = sle_pkg::STAT_FULL;
          else if (pos == 0 || pos > len + 1) r.status = sle_pkg::STAT_RANGE;
          else link_in(node_after(pos - 1), cmd.value_in);
        end
        sle_pkg::OP_GET: begin
          if (pos == 0 || pos > len) r.status = sle_pkg::STAT_RANGE;
          else r.value_out = data_mem[node_after(pos)];
        end
        sle_pkg::OP_LENGTH: r.count_or_position = 5'(len);
        sle_pkg::OP_DELETE_VALUE: begin
          r.status = sle_pkg::STAT_NOTFOUND;
          prev = 0;
          for (int c = 0; c < len; c++) begin
            cur = link_mem[prev];
            if (data_mem[cur] == cmd.value_in) begin
              r.value_out = unlink_after(prev);
              r.status = sle_pkg::STAT_OK;
              break;
            end
            prev = cur;
          end
        end
        sle_pkg::OP_DELETE_AT: begin
          if (pos == 0 || pos > len) r.status = sle_pkg::STAT_RANGE;
          else r.value_out = unlink_after(node_after(pos - 1));
        end
        sle_pkg::OP_REVERSE: begin
          if (len >= 2) begin
            cur = link_mem[0];
            link_mem[0] = 0;
            for (int c = 0; c < len && cur != 0; c++) begin
              nx = link_mem[cur];
              link_mem[cur] = link_mem[0];
              link_mem[0] = cur;
              cur = nx;
            end
          end
        end
        sle_pkg::OP_SORT: begin
          // Insertion sort: each node goes before the first one not smaller.
          if (len >= 2) begin
            cur = link_mem[link_mem[0]];
            link_mem[link_mem[0]] = 0;
            for (int c = 1; c < len && cur != 0; c++) begin
              nx = link_mem[cur];
              prev = 0;
              for (int n = 0; n < len; n++) begin
                s = link_mem[prev];
                if (s == 0 || !($signed(data_mem[s]) < $signed(data_mem[cur]))) break;
                prev = s;
              end
              link_mem[cur] = link_mem[prev];
              link_mem[prev] = cur;
              cur = nx;
            end
          end
        end
        sle_pkg::OP_CLEAR: begin
          cur = link_mem[0];
          link_mem[0] = 0;
          for (int c = 0; c < len && cur != 0; c++) begin
            nx = link_mem[cur];
            release_node(cur);
            cur = nx;
          end
        end
        sle_pkg::OP_FIND: begin
          r.status = sle_pkg::STAT_NOTFOUND;
          cur = link_mem[0];
          for (int c = 0; c < len && cur != 0; c++) begin
            if (data_mem[cur] == cmd.value_in) begin
              r.count_or_position = 5'(c + 1);
              r.status = sle_pkg::STAT_OK;
              break;
            end
            cur = link_mem[cur];
          end
        end
        default: ;
      endcase
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    // Compares one response with the oldest expectation.
    function void check_response(sle_pkg::rsp_t got);
      sle_pkg::rsp_t exp_rsp;
      checked++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected response %p", got);
        return;
      end
      exp_rsp = pending_rsp[0];
      pending_rsp.delete(0);
      if (got.value_out !== exp_rsp.value_out ||
          got.count_or_position !== exp_rsp.count_or_position ||
          got.status !== exp_rsp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: response %0d expected %p, got %p", checked, exp_rsp, got);
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sle_pkg::cmd_t  cmd_i = '0;
  logic           done_o;
  sle_pkg::rsp_t  rsp_o;

  list_scoreboard board = new();
  int send_idle_pct = 0;
  int cmds_sent = 0;

  static_linked_list_engine_core #(.NODE_COUNT(NODES)) dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .done_o, .rsp_o
  );

  always #5 clk_i = ~clk_i;

  // Response monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_response(rsp_o);
  end

  // Sends one command transaction, with a random idle gap first. The start
  // strobe stays high after acceptance until the next gap or command.
  task automatic send_cmd(logic [3:0] op, logic [31:0] v, logic [4:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= '{opcode: op, value_in: v, position: pos};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_command(cmd_i);
    cmds_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // Value drawn mostly from a small pool so that finds and deletes hit.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  task automatic random_phase(int n, int idle_pct);
    logic [3:0] op;
    send_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2: op = sle_pkg::OP_PUSH_BACK;
        3, 4:    op = sle_pkg::OP_PUSH_FRONT;
        5, 6:    op = sle_pkg::OP_INSERT;
        7:       op = sle_pkg::OP_CLEAR;
        8:       op = 4'($urandom_range(15));
        default: op = 4'($urandom_range(12));
      endcase
      send_cmd(op, pick_value(), 5'($urandom_range(1) ? $urandom_range(31) :
                                                        $urandom_range(16)));
    end
  endtask

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases, filling the store, ranges, sort and reverse.
    send_cmd(sle_pkg::OP_POP_BACK, 0, 0);
    send_cmd(sle_pkg::OP_POP_FRONT, 0, 0);
    send_cmd(sle_pkg::OP_GET, 0, 1);
    send_cmd(sle_pkg::OP_FIND, 5, 0);
    send_cmd(sle_pkg::OP_DELETE_VALUE, 5, 0);
    send_cmd(sle_pkg::OP_INSERT, 7, 0);
    send_cmd(sle_pkg::OP_INSERT, 7, 2);
    send_cmd(sle_pkg::OP_SORT, 0, 0);
    send_cmd(sle_pkg::OP_PUSH_BACK, 32'h7fffffff, 0);
    send_cmd(sle_pkg::OP_REVERSE, 0, 0);
    send_cmd(sle_pkg::OP_PUSH_FRONT, 32'h80000000, 0);
    send_cmd(sle_pkg::OP_INSERT, 3, 3);
    for (int i = 0; i < 12; i++) begin
      send_cmd(sle_pkg::OP_PUSH_BACK, 32'($signed(i % 4) - 1), 0);
    end
    send_cmd(sle_pkg::OP_INSERT, 1, 31);
    send_cmd(sle_pkg::OP_PUSH_FRONT, 1, 0);
    send_cmd(sle_pkg::OP_LENGTH, 0, 0);
    send_cmd(sle_pkg::OP_SORT, 0, 0);
    send_cmd(sle_pkg::OP_FIND, 3, 0);
    send_cmd(sle_pkg::OP_REVERSE, 0, 0);
    send_cmd(sle_pkg::OP_DELETE_AT, 0, 14);
    send_cmd(sle_pkg::OP_DELETE_AT, 0, 15);
    send_cmd(sle_pkg::OP_GET, 0, 0);
    send_cmd(4'd15, 32'hffffffff, 5'h1f);
    send_cmd(sle_pkg::OP_CLEAR, 0, 0);
    // Pause until every outstanding response has come back.
    drain();

    random_phase(300, 0);
    random_phase(300, 78);
    random_phase(300, 15);
    random_phase(300, 0);
    drain();

    $display("Covered %0d commands, %0d responses checked, %0d mismatches.",
             cmds_sent, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
